// File: hdl/bfsa_pkg.sv
// Package: types and codes for the best-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfsa_pkg;
   localparam logic [2:0] ST_ALLOC    = 3'd0;
   localparam logic [2:0] ST_FREED    = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_COMPACT  = 3'd3;
   localparam logic [2:0] ST_TOO_BIG  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_ZERO     = 3'd6;
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic        used;
      logic [7:0]  owner;
      logic [15:0] start;
      logic [15:0] length;
   } seg_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_REPORT
   } state_type;
endpackage
`default_nettype wire

// File: hdl/best_fit_segment_allocator_core.sv
// Top level: best-fit segment allocator with hole coalescing.
// A table rewrite (allocate, successful free) adds a shift pass after the scan;
// other requests go from the scan through the decide state straight to the report.
// Throughput: one request at a time, the next taken in the same cycle as the response is
// raised; a stalled response holds the following request in its report state.
// Reset or a mem_size write leaves one hole [0, mem_size) and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_segment_allocator_core #(
   parameter int MAX_SEGS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // proc_id[7:0], alloc_size[23:8]
   input  wire         req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // status[2:0], address[18:3], free_total[34:19], zero
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_data
);
   localparam int IW = $clog2(MAX_SEGS);
   localparam int CW = $clog2(MAX_SEGS + 1);
   localparam logic [CW-1:0] CMAX = CW'(MAX_SEGS);

   bfsa_pkg::seg_type mem [MAX_SEGS];
   bfsa_pkg::seg_type rd_ff, wr_data;
   logic              wr_en;
   logic [IW-1:0]     rd_addr, wr_addr;

   bfsa_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, ridx_ff, ridx_in, widx_ff, widx_in;
   logic          rvalid_ff, rvalid_in;
   logic          type_ff, type_in;
   logic [7:0]    id_ff, id_in;
   logic [15:0]   size_ff, size_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   logic [15:0]   blen_ff, blen_in, bstart_ff, bstart_in;
   logic [16:0]   sum_ff, sum_in;
   logic [2:0]    status_ff, status_in;
   logic [15:0]   addr_ff, addr_in;
   logic          split_ff, split_in;
   bfsa_pkg::seg_type carry_ff, carry_in;
   logic          have_ff, have_in;
   logic          rsp_v_ff, rsp_v_in;
   logic [39:0]   rsp_d_ff, rsp_d_in;
   logic          e0_ff, e0_in;
   logic [15:0]   msize_ff;

   // entry 0 after reset or mem_size write comes from a flag, not the memory
   bfsa_pkg::seg_type rd_eff;
   logic [IW-1:0] rd_idx_ff;
   always_comb begin
      rd_eff = rd_ff;
      if (e0_ff && rd_idx_ff == '0) begin
         rd_eff = '{used: 1'b0, owner: 8'd0, start: 16'd0, length: msize_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   assign csr_ready = (state_ff == bfsa_pkg::S_IDLE);
   assign req_tready = (state_ff == bfsa_pkg::S_IDLE) && !csr_valid;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfsa_pkg::S_IDLE;
         count_ff <= CW'(1);
         rsp_v_ff <= 1'b0;
         e0_ff <= 1'b1;
         msize_ff <= 16'd1024;
         rvalid_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_v_ff <= rsp_v_in;
         e0_ff <= e0_in;
         rvalid_ff <= rvalid_in;
         have_ff <= have_in;
         if (csr_valid && csr_ready) msize_ff <= csr_data;
      end
      ridx_ff <= ridx_in; widx_ff <= widx_in; type_ff <= type_in; id_ff <= id_in;
      size_ff <= size_in; found_ff <= found_in; best_ff <= best_in; blen_ff <= blen_in;
      bstart_ff <= bstart_in; sum_ff <= sum_in; status_ff <= status_in;
      addr_ff <= addr_in; split_ff <= split_in; carry_ff <= carry_in; rsp_d_ff <= rsp_d_in;
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; ridx_in = ridx_ff; widx_in = widx_ff;
      rvalid_in = 1'b0; type_in = type_ff; id_in = id_ff; size_in = size_ff;
      found_in = found_ff; best_in = best_ff; blen_in = blen_ff; bstart_in = bstart_ff;
      sum_in = sum_ff; status_in = status_ff; addr_in = addr_ff; split_in = split_ff;
      carry_in = carry_ff; have_in = have_ff; rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      e0_in = e0_ff; wr_en = 1'b0; wr_addr = '0; wr_data = rd_eff; rd_addr = '0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      unique case (state_ff)
         bfsa_pkg::S_IDLE: begin
            if (csr_valid) begin
               count_in = CW'(1);
               e0_in = 1'b1;
            end else if (req_tvalid) begin
               type_in = req_tuser; id_in = req_tdata[7:0]; size_in = req_tdata[23:8];
               found_in = 1'b0; sum_in = '0; ridx_in = '0;
               state_in = bfsa_pkg::S_SCAN;
            end
         end
         bfsa_pkg::S_SCAN: begin
            // issue reads 0..count-1, evaluate the one returned
            if (ridx_ff < count_ff) begin
               rd_addr = ridx_ff[IW-1:0];
               rvalid_in = 1'b1;
               ridx_in = ridx_ff + CW'(1);
            end
            if (rvalid_ff) begin
               if (!rd_eff.used) sum_in = sum_ff + 17'(rd_eff.length);
               if (type_ff == bfsa_pkg::REQ_FREE) begin
                  if (!found_ff && rd_eff.used && rd_eff.owner == id_ff) begin
                     found_in = 1'b1; best_in = rd_idx_ff; bstart_in = rd_eff.start;
                     blen_in = rd_eff.length;
                  end
               end else if (!rd_eff.used && rd_eff.length >= size_ff &&
                            (!found_ff || rd_eff.length < blen_ff)) begin
                  found_in = 1'b1; best_in = rd_idx_ff; blen_in = rd_eff.length;
                  bstart_in = rd_eff.start;
               end
            end
            if (!(ridx_ff < count_ff) && !rvalid_ff) state_in = bfsa_pkg::S_DECIDE;
         end
         bfsa_pkg::S_DECIDE: begin
            addr_in = '0; split_in = 1'b0; have_in = 1'b0;
            state_in = bfsa_pkg::S_REPORT;
            if (type_ff == bfsa_pkg::REQ_FREE) begin
               if (!found_ff) status_in = bfsa_pkg::ST_NOT_FOUND;
               else begin
                  status_in = bfsa_pkg::ST_FREED; addr_in = bstart_ff;
                  sum_in = sum_ff + 17'(blen_ff);
                  ridx_in = '0; widx_in = '0; state_in = bfsa_pkg::S_SHIFT;
               end
            end else if (size_ff == 16'd0) status_in = bfsa_pkg::ST_ZERO;
            else if (!found_ff)
               status_in = (sum_ff >= 17'(size_ff)) ? bfsa_pkg::ST_COMPACT
                                                   : bfsa_pkg::ST_TOO_BIG;
            else if (blen_ff > size_ff && count_ff >= CMAX) status_in = bfsa_pkg::ST_FULL;
            else begin
               status_in = bfsa_pkg::ST_ALLOC; addr_in = bstart_ff;
               split_in = blen_ff > size_ff;
               sum_in = sum_ff - 17'(size_ff);
               ridx_in = '0; widx_in = '0; state_in = bfsa_pkg::S_SHIFT;
            end
         end
         bfsa_pkg::S_SHIFT: begin
            // streaming rewrite: read in order, write at widx (never ahead of reads)
            if (ridx_ff < count_ff) begin
               rd_addr = ridx_ff[IW-1:0];
               rvalid_in = 1'b1;
               ridx_in = ridx_ff + CW'(1);
            end
            if (rvalid_ff) begin
               if (type_ff == bfsa_pkg::REQ_ALLOC) begin
                  if (have_ff) begin
                     // write held entry, keep this one for next slot
                     wr_en = 1'b1; wr_addr = widx_ff[IW-1:0]; wr_data = carry_ff;
                     carry_in = rd_eff; widx_in = widx_ff + CW'(1);
                  end else if (rd_idx_ff == best_ff) begin
                     wr_en = 1'b1; wr_addr = widx_ff[IW-1:0];
                     wr_data = '{used: 1'b1, owner: id_ff, start: rd_eff.start,
                                 length: size_ff};
                     widx_in = widx_ff + CW'(1);
                     if (split_ff) begin
                        have_in = 1'b1;
                        carry_in = '{used: 1'b0, owner: 8'd0,
                                     start: rd_eff.start + size_ff,
                                     length: rd_eff.length - size_ff};
                     end
                  end else begin
                     wr_en = 1'b1; wr_addr = widx_ff[IW-1:0]; wr_data = rd_eff;
                     widx_in = widx_ff + CW'(1);
                  end
               end else begin
                  // free + merge: carry is the last written entry
                  wr_data = rd_eff;
                  if (rd_idx_ff == best_ff) wr_data.used = 1'b0;
                  if (have_ff && !carry_ff.used && !wr_data.used) begin
                     wr_data = carry_ff;
                     wr_data.length = carry_ff.length + rd_eff.length;
                     wr_en = 1'b1; wr_addr = widx_ff[IW-1:0] - IW'(1);
                  end else begin
                     wr_en = 1'b1; wr_addr = widx_ff[IW-1:0];
                     widx_in = widx_ff + CW'(1);
                  end
                  carry_in = wr_data; have_in = 1'b1;
               end
               if (wr_addr == '0) e0_in = 1'b0;
            end
            if (!(ridx_ff < count_ff) && !rvalid_ff) begin
               if (have_ff && type_ff == bfsa_pkg::REQ_ALLOC) begin
                  wr_en = 1'b1; wr_addr = widx_ff[IW-1:0]; wr_data = carry_ff;
                  count_in = widx_ff + CW'(1);
               end else count_in = widx_ff;
               state_in = bfsa_pkg::S_REPORT;
            end
         end
         bfsa_pkg::S_REPORT: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1;
               rsp_d_in = {5'd0, sum_ff[15:0], addr_ff, status_ff};
               state_in = bfsa_pkg::S_IDLE;
            end
         end
         default: state_in = bfsa_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/bfsa_checker.sv
// Checker: port-level properties of the allocator core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bfsa_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= bfsa_pkg::ST_ZERO)
      else $error("bad status code");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");
   a_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] > bfsa_pkg::ST_FREED |-> rsp_tdata[18:3] == 16'd0)
      else $error("address set on failed request");
endmodule
bind best_fit_segment_allocator_core bfsa_checker u_bfsa_checker (.*);
`default_nettype wire
